FILE: hw/rtl/set_assoc_cache_lru_lookup_unit_macros.svh
// Assertion macros for the cache lookup unit; empty bodies when SYNTH is set.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// next-cycle implication
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/sacl_pkg.sv
// Shared constants and controller/datapath interface types for the cache lookup unit.
package sacl_pkg;

	localparam int ADDR_W          = 32;
	localparam int STAMP_W         = 32;
	localparam int COUNT_W         = 32;
	localparam int OUT_WAY_W       = 3;
	localparam int OUT_TAG_W       = 20;

	localparam int DEF_WAYS        = 8;
	localparam int DEF_SETS        = 64;
	localparam int DEF_OFFSET_BITS = 6;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // zero one row of the tag store
		logic load;       // take the address, start the set/tag split
		logic div_step;   // one step of the set/tag split
		logic rd;         // read the set's row
		logic look;       // tag compare, pick hit/free way
		logic scan_step;  // one LRU compare
		logic commit;     // write row back, update counters, emit result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic need_scan;
		logic scan_last;
	} status_t;

endpackage

FILE: hw/rtl/sacl_ctrl.sv
// Sequencing state machine of the cache lookup unit.
module sacl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output sacl_pkg::cmd_t   cmd,
	input  sacl_pkg::status_t status
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_LOOK  = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_WRITE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_READ;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = status.need_scan ? ST_SCAN : ST_WRITE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/sacl_datapath.sv
// Set/tag split, tag store, hit and LRU selection, counters and result registers.
module sacl_datapath #(
	parameter int WAYS        = sacl_pkg::DEF_WAYS,
	parameter int SETS        = sacl_pkg::DEF_SETS,
	parameter int OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sacl_pkg::cmd_t                       cmd,
	output sacl_pkg::status_t                    status,
	input  logic [sacl_pkg::ADDR_W-1:0]          address,
	output logic                                 done,
	output logic                                 hit,
	output logic [sacl_pkg::OUT_WAY_W-1:0]       way,
	output logic                                 evicted,
	output logic [sacl_pkg::OUT_TAG_W-1:0]       evicted_tag,
	output logic [sacl_pkg::COUNT_W-1:0]         hit_count,
	output logic [sacl_pkg::COUNT_W-1:0]         miss_count
);

	localparam int LINE_W    = sacl_pkg::ADDR_W - OFFSET_BITS;
	localparam int SET_W     = $clog2(SETS);
	localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
	localparam longint unsigned MAX_TAG = ((64'd1 << LINE_W) - 64'd1) / 64'(SETS);
	localparam int TAG_W     = $clog2(MAX_TAG + 64'd1);
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int STAMP_W   = sacl_pkg::STAMP_W;
	localparam int ENTRY_W   = 1 + TAG_W + STAMP_W;
	localparam int ROW_W     = WAYS * ENTRY_W;
	localparam int DIV_STEPS = 2;
	localparam int DCNT_W    = 2;
	// reciprocal of SETS, exact for every LINE_W-bit line number
	localparam int DIV_SHIFT = LINE_W + SET_W;
	localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) / 64'(SETS)) + 64'd1;

	// set/tag split: shift for power-of-two set counts, else reciprocal
	// multiply for the quotient, then one step for the remainder
	logic [LINE_W-1:0]   line_no;
	logic [LINE_W-1:0]   line_q;
	logic [LINE_W-1:0]   quo_q;
	logic [SET_W-1:0]    rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [2*LINE_W:0]   quo_prod;
	logic [LINE_W-1:0]   quo_mul;
	logic [TAG_W-1:0]    tag;

	assign line_no  = address[sacl_pkg::ADDR_W-1:OFFSET_BITS];
	assign quo_prod = (2*LINE_W+1)'(line_q) * (2*LINE_W+1)'(RECIP);
	assign quo_mul  = quo_q * LINE_W'(SETS);
	assign tag      = quo_q[TAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= SETS_POW2 ? '0 : DCNT_W'(DIV_STEPS);
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q <= line_no;
			if (SETS_POW2) begin
				quo_q <= line_no >> SET_W;
				rem_q <= line_no[SET_W-1:0];
			end else begin
				quo_q <= line_no;
				rem_q <= '0;
			end
		end else if (cmd.div_step) begin
			if (dcnt_q == DCNT_W'(DIV_STEPS)) begin
				quo_q <= LINE_W'(quo_prod >> DIV_SHIFT);
			end else begin
				rem_q <= SET_W'(line_q - quo_mul);
			end
		end
	end

	// tag store: one row per set, {valid, tag, stamp} per way
	logic [ROW_W-1:0] row_mem_q [SETS];
	logic [ROW_W-1:0] rd_row_q;
	logic [ROW_W-1:0] wr_row;
	logic [SET_W-1:0] clr_idx_q;
	logic [STAMP_W-1:0] clock_q;
	logic [STAMP_W-1:0] stamp_new;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			row_mem_q[clr_idx_q] <= '0;
		end else if (cmd.commit) begin
			row_mem_q[rem_q] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_row_q <= row_mem_q[rem_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= status.clr_last ? '0 : clr_idx_q + SET_W'(1);
		end
	end

	// row decode
	logic               way_valid [WAYS];
	logic [TAG_W-1:0]   way_tag   [WAYS];
	logic [STAMP_W-1:0] way_stamp [WAYS];

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			way_valid[w] = rd_row_q[w*ENTRY_W + ENTRY_W - 1];
			way_tag[w]   = rd_row_q[w*ENTRY_W + STAMP_W +: TAG_W];
			way_stamp[w] = rd_row_q[w*ENTRY_W +: STAMP_W];
		end
	end

	// parallel tag compare, lowest matching / lowest free way
	logic             hit_any, free_any;
	logic [WAY_W-1:0] hit_idx, free_idx;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (way_valid[w] && (way_tag[w] == tag)) begin
				hit_any = 1'b1;
				hit_idx = WAY_W'(w);
			end
			if (!way_valid[w]) begin
				free_any = 1'b1;
				free_idx = WAY_W'(w);
			end
		end
	end

	logic             hit_q, evict_q;
	logic [WAY_W-1:0] sel_q, scan_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q      <= hit_any;
			evict_q    <= !hit_any && !free_any;
			sel_q      <= hit_any ? hit_idx : free_idx;
			scan_idx_q <= WAY_W'(1);
		end else if (cmd.scan_step) begin
			// strict less-than keeps the lowest way among equal stamps
			if (way_stamp[scan_idx_q] < way_stamp[sel_q]) sel_q <= scan_idx_q;
			scan_idx_q <= scan_idx_q + WAY_W'(1);
		end
	end

	assign status.clr_last  = (clr_idx_q == SET_W'(SETS - 1));
	assign status.div_done  = (dcnt_q == '0);
	assign status.need_scan = (WAYS > 1) && !hit_any && !free_any;
	assign status.scan_last = (scan_idx_q == WAY_W'(WAYS - 1));

	// write-back row: selected way gets {valid, tag, new stamp}
	assign stamp_new = clock_q + STAMP_W'(1);

	always_comb begin
		wr_row = rd_row_q;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == sel_q) wr_row[w*ENTRY_W +: ENTRY_W] = {1'b1, tag, stamp_new};
		end
	end

	// counters and result registers
	logic [sacl_pkg::COUNT_W-1:0]   hits_q, misses_q;
	logic                           done_q, res_hit_q, res_evicted_q;
	logic [sacl_pkg::OUT_WAY_W-1:0] res_way_q;
	logic [sacl_pkg::OUT_TAG_W-1:0] res_evtag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				clock_q <= stamp_new;
				if (hit_q) begin
					hits_q <= hits_q + sacl_pkg::COUNT_W'(1);
				end else begin
					misses_q <= misses_q + sacl_pkg::COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_hit_q     <= hit_q;
			res_way_q     <= sacl_pkg::OUT_WAY_W'(sel_q);
			res_evicted_q <= evict_q;
			res_evtag_q   <= evict_q ? sacl_pkg::OUT_TAG_W'(way_tag[sel_q]) : '0;
		end
	end

	assign done        = done_q;
	assign hit         = res_hit_q;
	assign way         = res_way_q;
	assign evicted     = res_evicted_q;
	assign evicted_tag = res_evtag_q;
	assign hit_count   = hits_q;
	assign miss_count  = misses_q;

endmodule

FILE: hw/rtl/set_assoc_cache_lru_lookup_unit.sv
// Top level of the set-associative cache tag lookup unit with true LRU replacement.
//
//  channel   ports                                    handshake
//  --------  ---------------------------------------  --------------------------------
//  request   address                                  start && !busy at rising edge
//  result    hit way evicted evicted_tag              done high for exactly one cycle
//            hit_count miss_count
//
// Steps: a request first splits the address into set and tag (a shift for a
// power-of-two set count, otherwise a reciprocal multiply for the tag and a
// remainder step for the set), then reads the set row, compares tags, walks
// the stamps when every way is valid and none hits, and writes back.
// The result shows on the cycle after write-back; busy is already low then.
// Reset: a clearing pass zeroes one set row per cycle, with busy high
// throughout. The receiver cannot stall; results are never held.
`include "set_assoc_cache_lru_lookup_unit_macros.svh"

module set_assoc_cache_lru_lookup_unit #(
	parameter int WAYS        = sacl_pkg::DEF_WAYS,
	parameter int SETS        = sacl_pkg::DEF_SETS,
	parameter int OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [sacl_pkg::ADDR_W-1:0]       address,
	output logic                              done,
	output logic                              hit,
	output logic [sacl_pkg::OUT_WAY_W-1:0]    way,
	output logic                              evicted,
	output logic [sacl_pkg::OUT_TAG_W-1:0]    evicted_tag,
	output logic [sacl_pkg::COUNT_W-1:0]      hit_count,
	output logic [sacl_pkg::COUNT_W-1:0]      miss_count
);

	sacl_pkg::cmd_t    cmd;
	sacl_pkg::status_t status;

	// controller: clear pass, then one request at a time
	sacl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	// datapath: address split, tag store, LRU pick, counters, result regs
	sacl_datapath #(
		.WAYS        (WAYS),
		.SETS        (SETS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.address     (address),
		.done        (done),
		.hit         (hit),
		.way         (way),
		.evicted     (evicted),
		.evicted_tag (evicted_tag),
		.hit_count   (hit_count),
		.miss_count  (miss_count)
	);

	// an accepted request keeps the unit busy until its write-back
	`SACL_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// every write-back produces exactly one result strobe on the next cycle
	`SACL_ASSERT_NXT(a_commit_done, clk, arst_n, cmd.commit, done)
	// results never come back to back
	`SACL_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	// a hit never evicts
	`SACL_ASSERT_IMP(a_hit_no_evict, clk, arst_n, done && hit, !evicted && (evicted_tag == '0))

endmodule

FILE: verif/set_assoc_cache_lru_lookup_unit_tb.sv
// Self-checking testbench for the set-associative cache lookup unit with true LRU replacement.
module set_assoc_cache_lru_lookup_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Geometry under test: the block's defaults.
	localparam int WAYS        = sacl_pkg::DEF_WAYS;
	localparam int SETS        = sacl_pkg::DEF_SETS;
	localparam int OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS;

	// A slow correct run: ~1850 requests, each with its busy time, its idle gap
	// and its result, plus the clearing pass after reset. The limit allows
	// several times what that takes.
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 24;

	// One memory reference waiting to be sent. idle_before is the number of
	// cycles start stays low ahead of it; wait_drained holds it back until
	// every outstanding result has come back.
	typedef struct {
		logic [sacl_pkg::ADDR_W-1:0] addr;
		int                          idle_before;
		bit                          wait_drained;
	} cache_ref_t;

	typedef struct packed {
		logic                           hit;
		logic [sacl_pkg::OUT_WAY_W-1:0] way;
		logic                           evicted;
		logic [sacl_pkg::OUT_TAG_W-1:0] evicted_tag;
		logic [sacl_pkg::COUNT_W-1:0]   hit_count;
		logic [sacl_pkg::COUNT_W-1:0]   miss_count;
	} lookup_result_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic [sacl_pkg::ADDR_W-1:0]       address = '0;
	logic                              busy;
	logic                              done;
	logic                              hit;
	logic [sacl_pkg::OUT_WAY_W-1:0]    way;
	logic                              evicted;
	logic [sacl_pkg::OUT_TAG_W-1:0]    evicted_tag;
	logic [sacl_pkg::COUNT_W-1:0]      hit_count;
	logic [sacl_pkg::COUNT_W-1:0]      miss_count;

	// Requests still to be sent, and results owed by the block in order.
	cache_ref_t     pending_refs[$];
	lookup_result_t owed_results[$];
	cache_ref_t     next_ref;
	lookup_result_t got_owed;
	int             queued_refs;
	int             accepted_refs;
	int             idle_cnt;
	int             errors;
	int             cycles;

	// Shadow copy of the tag store, timestamps and counters. bit arrays start
	// at zero, which matches the block's state after its clearing pass.
	bit [31:0]                    shadow_tag   [SETS][WAYS];
	bit                           shadow_valid [SETS][WAYS];
	bit [sacl_pkg::STAMP_W-1:0]   shadow_stamp [SETS][WAYS];
	bit [sacl_pkg::STAMP_W-1:0]   ref_clock;
	bit [sacl_pkg::COUNT_W-1:0]   hits_seen;
	bit [sacl_pkg::COUNT_W-1:0]   misses_seen;

	set_assoc_cache_lru_lookup_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.address     (address),
		.done        (done),
		.hit         (hit),
		.way         (way),
		.evicted     (evicted),
		.evicted_tag (evicted_tag),
		.hit_count   (hit_count),
		.miss_count  (miss_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Look one address up in the shadow cache and update it, the way the
	// block does: the reference clock ticks first; a hit refreshes the way's
	// stamp; a miss takes the lowest invalid way, else the lowest-numbered
	// way holding the smallest stamp (unsigned compare).
	function automatic lookup_result_t cache_lookup(input logic [31:0] addr);
		logic [31:0]    line_no;
		logic [31:0]    tag;
		int             set_idx;
		int             sel;
		bit             found;
		bit             free_found;
		lookup_result_t r;
		line_no = addr >> OFFSET_BITS;
		set_idx = int'(line_no % SETS);
		tag     = line_no / SETS;
		sel     = 0;
		found   = 1'b0;
		free_found = 1'b0;
		r       = '0;
		ref_clock = ref_clock + 1;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
				sel   = w;
				found = 1'b1;
			end
		end
		if (found) begin
			hits_seen = hits_seen + 1;
			shadow_stamp[set_idx][sel] = ref_clock;
		end else begin
			misses_seen = misses_seen + 1;
			for (int w = 0; w < WAYS; w++) begin
				if (!free_found && !shadow_valid[set_idx][w]) begin
					sel        = w;
					free_found = 1'b1;
				end
			end
			if (!free_found) begin
				sel = 0;
				for (int w = 1; w < WAYS; w++) begin
					if (shadow_stamp[set_idx][w] < shadow_stamp[set_idx][sel]) begin
						sel = w;
					end
				end
				r.evicted     = 1'b1;
				r.evicted_tag = shadow_tag[set_idx][sel][sacl_pkg::OUT_TAG_W-1:0];
			end
			shadow_valid[set_idx][sel] = 1'b1;
			shadow_tag[set_idx][sel]   = tag;
			shadow_stamp[set_idx][sel] = ref_clock;
		end
		r.hit        = found;
		r.way        = sel[sacl_pkg::OUT_WAY_W-1:0];
		r.hit_count  = hits_seen;
		r.miss_count = misses_seen;
		return r;
	endfunction

	function automatic logic [31:0] line_addr(input logic [31:0] tag, input int set_idx,
		input int offset);
		return ((tag * SETS + set_idx) << OFFSET_BITS) | offset;
	endfunction

	task automatic queue_ref(input logic [31:0] addr, input int idle_before,
		input bit wait_drained);
		cache_ref_t c;
		c.addr         = addr;
		c.idle_before  = idle_before;
		c.wait_drained = wait_drained;
		pending_refs.push_back(c);
		queued_refs++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver. The request on the ports is taken at an edge where start is
	// high and busy is low; that is where the shadow cache is stepped. Start
	// is then either kept up with the next address or dropped (an idle gap, a wait
	// for the drain, or no request left), with exactly one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			address  <= '0;
			idle_cnt <= 0;
		end else begin
			if (start && !busy) begin
				owed_results.push_back(cache_lookup(address));
				accepted_refs++;
			end
			if (start && busy) begin
				// request still waiting for the block: hold it steady
			end else if (pending_refs.size() == 0) begin
				start <= 1'b0;
			end else if (idle_cnt < pending_refs[0].idle_before) begin
				start    <= 1'b0;
				idle_cnt <= idle_cnt + 1;
			end else if (pending_refs[0].wait_drained && owed_results.size() != 0) begin
				start <= 1'b0;
			end else begin
				next_ref = pending_refs.pop_front();
				start    <= 1'b1;
				address  <= next_ref.addr;
				idle_cnt <= 0;
			end
		end
	end

	// Monitor. done marks a result for exactly one cycle; every one of them
	// must match the oldest owed result field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				$display("%0t ns: result with no request outstanding, expected none, actual hit=%0b way=%0d",
					$time, hit, way);
				errors++;
			end else begin
				got_owed = owed_results.pop_front();
				check_field("hit", got_owed.hit, hit);
				check_field("way", got_owed.way, way);
				check_field("evicted", got_owed.evicted, evicted);
				check_field("evicted_tag", got_owed.evicted_tag, evicted_tag);
				check_field("hit_count", got_owed.hit_count, hit_count);
				check_field("miss_count", got_owed.miss_count, miss_count);
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] tag_pool[10];
		int          hot_sets[3];
		logic [31:0] recent[$];
		logic [31:0] a;
		int          set_idx;
		int          roll;
		int          idle;
		bit          calm;
		errors        = 0;
		cycles        = 0;
		queued_refs   = 0;
		accepted_refs = 0;
		ref_clock     = '0;
		hits_seen     = '0;
		misses_seen   = '0;

		// Directed part.
		// Lowest address: cold miss into set 0, then a hit on the same line
		// from its last byte.
		queue_ref(32'h0000_0000, 0, 1'b0);
		queue_ref(32'h0000_003F, 0, 1'b0);
		// Highest address: set SETS-1, all-ones tag; then hit it again, which
		// also refreshes its stamp.
		queue_ref(32'hFFFF_FFFF, 0, 1'b0);
		queue_ref(32'hFFFF_FFC0, 2, 1'b0);
		// Fill the remaining ways of the top set with tags 1..7.
		for (int t = 1; t < WAYS; t++) begin
			queue_ref(line_addr(t, SETS - 1, t * 8), t % 3, 1'b0);
		end
		// Refresh tag 1, then miss with tag 0 once the pipe is empty: the
		// all-ones tag in way 0 is now the oldest and gets evicted.
		queue_ref(line_addr(1, SETS - 1, 63), 0, 1'b0);
		queue_ref(line_addr(0, SETS - 1, 0), 0, 1'b1);
		// Alternating tag patterns push out the next oldest lines.
		queue_ref(line_addr(32'hAAAAA, SETS - 1, 21), 0, 1'b0);
		queue_ref(line_addr(32'h55555, SETS - 1, 42), 0, 1'b0);
		// Top address bit alone: set 0, second way.
		queue_ref(32'h8000_0000, 5, 1'b0);
		// Bring the all-ones tag back in (evicts again), then hit tag 0.
		queue_ref(32'hFFFF_FFFF, 0, 1'b0);
		queue_ref(line_addr(0, SETS - 1, 7), 0, 1'b0);

		// Random part: six phases of 300 references. Most references draw a
		// tag from a pool of ten over a few hot sets, so with eight ways the
		// sets fill, hit and evict all the time; the rest replay a recent
		// address or are fully random. Every phase opens with a drained pipe,
		// and every third phase runs back to back with no idle cycles.
		for (int phase = 0; phase < 6; phase++) begin
			calm = (phase % 3 == 1);
			foreach (tag_pool[i]) begin
				tag_pool[i] = $urandom_range(0, (1 << sacl_pkg::OUT_TAG_W) - 1);
			end
			foreach (hot_sets[i]) begin
				hot_sets[i] = $urandom_range(0, SETS - 1);
			end
			for (int n = 0; n < 300; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					// spread over all sets in the last phase
					set_idx = (phase == 5) ? $urandom_range(0, SETS - 1)
						: hot_sets[$urandom_range(0, 2)];
					a = line_addr(tag_pool[$urandom_range(0, 9)], set_idx,
						$urandom_range(0, (1 << OFFSET_BITS) - 1));
				end else if (roll < 85 && recent.size() != 0) begin
					a = recent[$urandom_range(0, recent.size() - 1)];
				end else begin
					a = $urandom;
				end
				recent.push_back(a);
				if (recent.size() > 16) begin
					void'(recent.pop_front());
				end
				// mostly short gaps, a few long ones
				roll = $urandom_range(0, 99);
				if (calm || roll < 55) begin
					idle = 0;
				end else if (roll < 90) begin
					idle = $urandom_range(1, 4);
				end else begin
					idle = $urandom_range(10, 40);
				end
				queue_ref(a, idle, n == 0);
			end
		end

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request went in and every result came back, then
		// let the block run on for a while in case it emits anything extra.
		while (accepted_refs != queued_refs || owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (owed_results.size() != 0) begin
			$display("%0t ns: results missing, expected %0d more, actual 0",
				$time, owed_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
